>>> rtl/core/drct_pkg.sv
package drct_pkg;

  localparam int RING_ENTRIES = 32;
  localparam int IDX_W = $clog2(RING_ENTRIES);
  localparam int FRAG_MAX_BYTES = 4096;
  localparam int MAX_DESC_WORDS = 65534;
  localparam int FRAG_W = 13;
  localparam int REQ_W = 20;
  localparam int BYTES_W = 32;
  localparam int STAT_W = 5;

  localparam logic [STAT_W-1:0] CAUSE_MASK = 5'h1C;
  localparam int HALTED_POS = 0;

  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    ACT_START   = 3'd0,
    ACT_ACK     = 3'd1,
    ACT_REFILL  = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_RESTART = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REQ_FRAG  = 1'b0,
    REG_TOTAL     = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_IRQ   = 1'b1
  } req_t;

endpackage

>>> rtl/core/dma_ring_completion_tracker.sv
// Completion tracker for a cyclic ring of playback descriptors. A start transaction
// (in_tuser = 0) produces one result; an interrupt transaction (in_tuser = 1) on an
// active stream with a completion cause set produces an acknowledge, one refill or stop
// result per completed descriptor and an optional restart, and is silently dropped
// otherwise. Results leave one per cycle, unless out_tready holds them, through a single
// output register, and a walk covers at most 31 descriptors; one shared 33-bit add and
// compare against the stream length is stepped once per descriptor by the sequencer, and
// in_tready stays low until the item's last result is loaded. Configuration writes are
// taken in any cycle.
module dma_ring_completion_tracker import drct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // status_now[4:0], current_index[9:5], status_after[14:10], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // entry_index[4:0], ack_bits[9:5], fragment_bytes_out[22:10],
  // done_bytes[54:23], playing_index[59:55], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // action[2:0]
  output logic [2:0]            out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_WALK,
    S_RESTART
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_ENTRIES - 1);
  localparam logic [REQ_W-1:0] REQ_MAX = REQ_W'(FRAG_MAX_BYTES);
  localparam logic [REQ_W-1:0] REQ_DESC_CAP = REQ_W'(2 * MAX_DESC_WORDS);
  localparam logic [REQ_W-1:0] REQ_MIN = REQ_W'(4);

  state_t               state_r, state_nxt;
  logic                 active_r, active_nxt;
  logic [IDX_W-1:0]     next_idx_r, next_idx_nxt;
  logic [BYTES_W-1:0]   played_r, played_nxt;
  logic [FRAG_W-1:0]    frag_r, frag_nxt;
  logic [REQ_W-1:0]     req_frag_r, req_frag_nxt;
  logic [BYTES_W-1:0]   total_r, total_nxt;
  logic [IDX_W-1:0]     steps_r, steps_nxt;

  req_t                 type_r, type_nxt;
  logic [STAT_W-1:0]    st_now_r, st_now_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic                 halted_r, halted_nxt;

  logic                 ov_r, ov_nxt;
  action_t              o_act_r, o_act_nxt;
  logic [IDX_W-1:0]     o_ent_r, o_ent_nxt;
  logic [STAT_W-1:0]    o_ack_r, o_ack_nxt;
  logic [FRAG_W-1:0]    o_frag_r, o_frag_nxt;
  logic [BYTES_W-1:0]   o_played_r, o_played_nxt;
  logic [IDX_W-1:0]     o_play_r, o_play_nxt;
  logic                 o_last_r, o_last_nxt;

  logic                 out_free;
  logic [REQ_W-1:0]     f0, f1, f2, f3;
  logic [BYTES_W:0]     sum;
  logic [BYTES_W-1:0]   sum_sat;
  logic [IDX_W-1:0]     idx_inc;
  logic                 in_acc;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !ov_r || out_tready;

  // fragment size derivation
  always_comb begin
    f0 = (req_frag_r == '0) ? REQ_MAX : req_frag_r;
    f1 = {f0[REQ_W-1:2], 2'b00};
    f2 = (f1 > REQ_MAX) ? REQ_MAX : f1;
    f3 = (f2 > REQ_DESC_CAP) ? REQ_DESC_CAP : f2;
    if (f3 < REQ_MIN) begin
      f3 = REQ_MIN;
    end
  end

  // shared add and saturate unit
  assign sum     = {1'b0, played_r} + {{(BYTES_W+1-FRAG_W){1'b0}}, frag_r};
  assign sum_sat = sum[BYTES_W] ? {BYTES_W{1'b1}} : sum[BYTES_W-1:0];
  assign idx_inc = (next_idx_r == LAST_IDX) ? '0 : next_idx_r + IDX_W'(1);

  always_comb begin
    state_nxt    = state_r;
    active_nxt   = active_r;
    next_idx_nxt = next_idx_r;
    played_nxt   = played_r;
    frag_nxt     = frag_r;
    req_frag_nxt = req_frag_r;
    total_nxt    = total_r;
    steps_nxt    = steps_r;
    type_nxt     = type_r;
    st_now_nxt   = st_now_r;
    cur_nxt      = cur_r;
    halted_nxt   = halted_r;
    ov_nxt       = ov_r && !out_tready;
    o_act_nxt    = o_act_r;
    o_ent_nxt    = o_ent_r;
    o_ack_nxt    = o_ack_r;
    o_frag_nxt   = o_frag_r;
    o_played_nxt = o_played_r;
    o_play_nxt   = o_play_r;
    o_last_nxt   = o_last_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REQ_FRAG: req_frag_nxt = cfg_data[REQ_W-1:0];
        REG_TOTAL:    total_nxt    = cfg_data[BYTES_W-1:0];
        default:      total_nxt    = total_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          type_nxt   = req_t'(in_tuser);
          st_now_nxt = in_tdata[STAT_W-1:0];
          cur_nxt    = in_tdata[STAT_W+IDX_W-1:STAT_W];
          halted_nxt = in_tdata[STAT_W+IDX_W+HALTED_POS];
          // drop interrupts on an idle stream or without a cause
          if (req_t'(in_tuser) == REQ_START ||
              (active_r && (in_tdata[STAT_W-1:0] & CAUSE_MASK) != '0)) begin
            state_nxt = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          o_play_nxt = '0;
          steps_nxt = '0;
          if (type_r == REQ_START) begin
            frag_nxt     = f3[FRAG_W-1:0];
            next_idx_nxt = '0;
            played_nxt   = '0;
            active_nxt   = 1'b1;
            o_act_nxt    = ACT_START;
            o_ent_nxt    = LAST_IDX;
            o_ack_nxt    = CAUSE_MASK;
            o_frag_nxt   = f3[FRAG_W-1:0];
            o_played_nxt = '0;
            o_last_nxt   = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            o_act_nxt    = ACT_ACK;
            o_ent_nxt    = '0;
            o_ack_nxt    = st_now_r & CAUSE_MASK;
            o_frag_nxt   = frag_r;
            o_played_nxt = played_r;
            o_last_nxt   = (next_idx_r == cur_r) && !halted_r;
            priority if (next_idx_r != cur_r) begin
              state_nxt = S_WALK;
            end else if (halted_r) begin
              state_nxt = S_RESTART;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_WALK: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          steps_nxt    = steps_r + IDX_W'(1);
          next_idx_nxt = idx_inc;
          played_nxt   = sum_sat;
          o_ent_nxt    = next_idx_r;
          o_frag_nxt   = frag_r;
          o_played_nxt = sum_sat;
          o_play_nxt   = idx_inc;
          if (sum_sat >= total_r) begin
            active_nxt = 1'b0;
            o_act_nxt  = ACT_STOP;
            o_ack_nxt  = CAUSE_MASK;
            o_last_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            o_act_nxt = ACT_REFILL;
            o_ack_nxt = '0;
            priority if (idx_inc != cur_r && (steps_r + IDX_W'(1)) < LAST_IDX) begin
              o_last_nxt = 1'b0;
              state_nxt  = S_WALK;
            end else if (halted_r) begin
              o_last_nxt = 1'b0;
              state_nxt  = S_RESTART;
            end else begin
              o_last_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
        end
      end
      S_RESTART: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          o_act_nxt    = ACT_RESTART;
          o_ent_nxt    = '0;
          o_ack_nxt    = '0;
          o_frag_nxt   = frag_r;
          o_played_nxt = played_r;
          o_play_nxt   = '0;
          o_last_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      active_r   <= 1'b0;
      next_idx_r <= '0;
      played_r   <= '0;
      frag_r     <= FRAG_W'(FRAG_MAX_BYTES);
      req_frag_r <= '0;
      total_r    <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      next_idx_r <= next_idx_nxt;
      played_r   <= played_nxt;
      frag_r     <= frag_nxt;
      req_frag_r <= req_frag_nxt;
      total_r    <= total_nxt;
      ov_r       <= ov_nxt;
    end
    steps_r    <= steps_nxt;
    type_r     <= type_nxt;
    st_now_r   <= st_now_nxt;
    cur_r      <= cur_nxt;
    halted_r   <= halted_nxt;
    o_act_r    <= o_act_nxt;
    o_ent_r    <= o_ent_nxt;
    o_ack_r    <= o_ack_nxt;
    o_frag_r   <= o_frag_nxt;
    o_played_r <= o_played_nxt;
    o_play_r   <= o_play_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = o_act_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {{(OUT_DATA_W-2*IDX_W-STAT_W-FRAG_W-BYTES_W){1'b0}},
                       o_play_r, o_played_r, o_frag_r, o_ack_r, o_ent_r};

endmodule
